### rtl/i2cs_pkg.sv
`timescale 1ns / 1ps

package i2cs_pkg;

    // bus phase of the byte sequencer
    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_ADDR      = 3'd1,
        PH_SEND      = 3'd2,
        PH_ACK_WAIT  = 3'd3,
        PH_ACK_CHECK = 3'd4,
        PH_RX_WAIT   = 3'd5,
        PH_RX_ACK    = 3'd6
    } phase_t;

    // what the shifter does next
    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_ACK_BIT = 3'd1,
        ACT_BYTE    = 3'd2,
        ACT_ARM     = 3'd3,
        ACT_STOP    = 3'd4,
        ACT_REARM   = 3'd5
    } action_t;

    // event kind
    localparam logic KIND_START    = 1'b0;
    localparam logic KIND_OVERFLOW = 1'b1;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    typedef struct packed {
        logic       kind;
        logic [7:0] line_byte;
        logic       stop_seen;
        logic [7:0] tx_byte;
        logic       accept_write;
    } item_t;

    typedef struct packed {
        action_t    action;
        logic       sda_drive;
        logic [7:0] shift_out;
        logic [7:0] byte_index;
        logic       read_strobe;
        logic       write_strobe;
        logic [7:0] write_data;
        logic       addressed;
        logic       is_read;
    } result_t;

endpackage

### rtl/i2cs_step.sv
`timescale 1ns / 1ps

module i2cs_step (
    input  i2cs_pkg::item_t   item,
    input  i2cs_pkg::phase_t  phase,
    input  logic [7:0]        byte_count,
    input  logic [7:0]        own_address,
    output i2cs_pkg::phase_t  phase_next,
    output logic [7:0]        byte_count_next,
    output i2cs_pkg::result_t result
);
    import i2cs_pkg::*;

    logic addr_match;

    assign addr_match = (item.line_byte == 8'h00)
                     || ({item.line_byte[7:1], 1'b0} == own_address);

    always_comb
    begin
        phase_next      = phase;
        byte_count_next = byte_count;
        result          = '0;
        result.action   = ACT_NONE;
        if (item.kind == KIND_START)
        begin
            if (item.stop_seen)
            begin
                phase_next    = PH_IDLE;
                result.action = ACT_STOP;
            end
            else
            begin
                phase_next    = PH_ADDR;
                result.action = ACT_ARM;
            end
        end
        else
        begin
            case (phase)
                PH_ADDR:
                begin
                    if (addr_match)
                    begin
                        byte_count_next  = 8'd0;
                        phase_next       = item.line_byte[0] ? PH_SEND : PH_RX_WAIT;
                        result.action    = ACT_ACK_BIT;
                        result.sda_drive = 1'b1;
                        result.addressed = 1'b1;
                        result.is_read   = item.line_byte[0];
                    end
                    else
                    begin
                        phase_next    = PH_IDLE;
                        result.action = ACT_REARM;
                    end
                end
                PH_ACK_WAIT:
                begin
                    phase_next    = PH_ACK_CHECK;
                    result.action = ACT_ACK_BIT;
                end
                PH_ACK_CHECK, PH_SEND:
                begin
                    // master nack ends the read
                    if (phase == PH_ACK_CHECK && item.line_byte != 8'h00)
                    begin
                        phase_next    = PH_IDLE;
                        result.action = ACT_REARM;
                    end
                    else
                    begin
                        phase_next         = PH_ACK_WAIT;
                        result.action      = ACT_BYTE;
                        result.sda_drive   = 1'b1;
                        result.shift_out   = item.tx_byte;
                        result.byte_index  = byte_count;
                        result.read_strobe = 1'b1;
                        byte_count_next    = byte_count + 8'd1;
                    end
                end
                PH_RX_WAIT:
                begin
                    phase_next    = PH_RX_ACK;
                    result.action = ACT_BYTE;
                end
                PH_RX_ACK:
                begin
                    phase_next          = PH_RX_WAIT;
                    result.action       = ACT_ACK_BIT;
                    result.sda_drive    = item.accept_write;
                    result.byte_index   = byte_count;
                    result.write_strobe = 1'b1;
                    result.write_data   = item.line_byte;
                    byte_count_next     = byte_count + 8'd1;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/i2c_slave_byte_fsm.sv
`timescale 1ns / 1ps
// an accepted event word waits in the input register, its result word in the result register
// throughput: one event word per cycle unless the master side stalls; the decode between the
//   input register and the result register is combinational
// reset: rst_n asynchronous active low; phase goes idle, byte counter and own address clear,
//   both pipeline stages empty

module i2c_slave_byte_fsm (
    input  logic                               clk,
    input  logic                               rst_n,
    // event words
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // line_byte[7:0], stop_seen[8], tx_byte[16:9], accept_write[17], zero[23:18]
    input  logic [i2cs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // kind[0]
    input  logic                               s_axis_tuser,
    // result words
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // action[2:0], sda_drive[3], shift_out[11:4], byte_index[19:12], read_strobe[20],
    // write_strobe[21], write_data[29:22], addressed[30], is_read[31]
    output logic [i2cs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import i2cs_pkg::*;

    // own address register, byte addresses 0 to 3 (paddr[2] low)
    logic [7:0] own_address_reg;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready & (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? {24'd0, own_address_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg <= 8'd0;
        end
        else if (cfg_write)
        begin
            own_address_reg <= pwdata[7:0];
        end
    end

    // input stage
    logic  in_valid_reg;
    item_t in_item_reg;
    item_t in_item;
    logic  advance;

    // result stage
    logic    out_valid_reg;
    result_t out_result_reg;
    result_t result_next;

    // sequencer state, updated when an event moves into the result stage
    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] byte_count_reg;
    logic [7:0] byte_count_next;

    assign in_item.kind         = s_axis_tuser;
    assign in_item.line_byte    = s_axis_tdata[7:0];
    assign in_item.stop_seen    = s_axis_tdata[8];
    assign in_item.tx_byte      = s_axis_tdata[16:9];
    assign in_item.accept_write = s_axis_tdata[17];

    // result stage takes a word when empty or being drained
    assign advance       = in_valid_reg & (~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~in_valid_reg | advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg <= in_item;
        end
    end

    i2cs_step u_step (
        .item            (in_item_reg),
        .phase           (phase_reg),
        .byte_count      (byte_count_reg),
        .own_address     (own_address_reg),
        .phase_next      (phase_next),
        .byte_count_next (byte_count_next),
        .result          (result_next)
    );

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            byte_count_reg <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_result_reg.is_read,
                            out_result_reg.addressed,
                            out_result_reg.write_data,
                            out_result_reg.write_strobe,
                            out_result_reg.read_strobe,
                            out_result_reg.byte_index,
                            out_result_reg.shift_out,
                            out_result_reg.sda_drive,
                            out_result_reg.action};

endmodule

### dv/i2c_slave_byte_fsm_tb.sv
`timescale 1ns / 1ps

module i2c_slave_byte_fsm_tb;
    import i2cs_pkg::*;

    // predicts the sequencer step by step and holds the result words still due
    class bus_step_predictor;
        phase_t     phase;
        logic [7:0] byte_count;
        logic [7:0] own_addr;
        result_t    due[$];
        int         fails;
        int         checked;
        string      field_name[9] = '{"action", "sda_drive", "shift_out", "byte_index",
                                      "read_strobe", "write_strobe", "write_data",
                                      "addressed", "is_read"};

        function new();
            phase      = PH_IDLE;
            byte_count = 8'd0;
            own_addr   = 8'd0;
            fails      = 0;
            checked    = 0;
        endfunction

        function void set_own_addr(logic [31:0] value);
            own_addr = value[7:0];
        endfunction

        // master read: hand out the host byte and count it
        function result_t load_tx(logic [7:0] tx);
            result_t r;
            r             = '0;
            r.action      = ACT_BYTE;
            r.sda_drive   = 1'b1;
            r.shift_out   = tx;
            r.byte_index  = byte_count;
            r.read_strobe = 1'b1;
            byte_count    = byte_count + 8'd1;
            phase         = PH_ACK_WAIT;
            return r;
        endfunction

        // one accepted event word
        function void take_event(item_t ev);
            result_t r;
            r = '0;
            if (ev.kind == KIND_START) begin
                // start restarts from any phase, stop parks it
                if (ev.stop_seen) begin
                    phase    = PH_IDLE;
                    r.action = ACT_STOP;
                end
                else begin
                    phase    = PH_ADDR;
                    r.action = ACT_ARM;
                end
            end
            else begin
                case (phase)
                    PH_ADDR: begin
                        if (ev.line_byte == 8'd0 || {ev.line_byte[7:1], 1'b0} == own_addr) begin
                            byte_count  = 8'd0;
                            phase       = ev.line_byte[0] ? PH_SEND : PH_RX_WAIT;
                            r.action    = ACT_ACK_BIT;
                            r.sda_drive = 1'b1;
                            r.addressed = 1'b1;
                            r.is_read   = ev.line_byte[0];
                        end
                        else begin
                            phase    = PH_IDLE;
                            r.action = ACT_REARM;
                        end
                    end
                    PH_ACK_WAIT: begin
                        phase    = PH_ACK_CHECK;
                        r.action = ACT_ACK_BIT;
                    end
                    PH_ACK_CHECK: begin
                        // anything but zero on the ack bit is a master nack
                        if (ev.line_byte != 8'd0) begin
                            phase    = PH_IDLE;
                            r.action = ACT_REARM;
                        end
                        else begin
                            r = load_tx(ev.tx_byte);
                        end
                    end
                    PH_SEND: r = load_tx(ev.tx_byte);
                    PH_RX_WAIT: begin
                        phase    = PH_RX_ACK;
                        r.action = ACT_BYTE;
                    end
                    PH_RX_ACK: begin
                        // host nack only releases sda, phase still moves on
                        phase          = PH_RX_WAIT;
                        r.action       = ACT_ACK_BIT;
                        r.sda_drive    = ev.accept_write;
                        r.byte_index   = byte_count;
                        r.write_strobe = 1'b1;
                        r.write_data   = ev.line_byte;
                        byte_count     = byte_count + 8'd1;
                    end
                    default: phase = PH_IDLE;   // idle and the unused code ignore overflow
                endcase
            end
            due.push_back(r);
        endfunction

        // one accepted result word against the oldest prediction
        function void match_result(logic [OUT_DATA_W-1:0] word);
            result_t    want;
            logic [7:0] want_f[9];
            logic [7:0] got_f[9];
            if (due.size() == 0) begin
                $error("result word %h with nothing predicted", word);
                fails++;
                return;
            end
            want = due.pop_front();
            checked++;
            want_f = '{8'(want.action), 8'(want.sda_drive), want.shift_out, want.byte_index,
                       8'(want.read_strobe), 8'(want.write_strobe), want.write_data,
                       8'(want.addressed), 8'(want.is_read)};
            got_f  = '{8'(word[2:0]), 8'(word[3]), word[11:4], word[19:12], 8'(word[20]),
                       8'(word[21]), word[29:22], 8'(word[30]), 8'(word[31])};
            foreach (want_f[i]) begin
                if (got_f[i] !== want_f[i]) begin
                    $error("%s: expected %0h, actual %0h", field_name[i], want_f[i], got_f[i]);
                    fails++;
                end
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [2:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    bus_step_predictor sb = new();

    bit         quiet;          // stretch with no idling on either side
    logic [7:0] own_cfg;        // address setting in force
    int         events_sent;
    int         settings_used;

    localparam logic [2:0] REG_OWN_ADDRESS = 3'd0;

    i2c_slave_byte_fsm u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run-away guard
    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // result side: random stall before each word, then check it
    initial
    begin : result_sink
        int stall;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (m_axis_tvalid !== 1'b1);
            sb.match_result(m_axis_tdata);
        end
    end

    // one event word, with a random gap ahead of it; called at a rising edge
    task automatic put_event(bit kind, bit [7:0] line, bit stop, bit [7:0] tx, bit acc);
        int    gap;
        item_t ev;
        gap = quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {6'd0, acc, tx, stop, line};
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        ev.kind         = kind;
        ev.line_byte    = line;
        ev.stop_seen    = stop;
        ev.tx_byte      = tx;
        ev.accept_write = acc;
        sb.take_event(ev);
        events_sent++;
    endtask

    task automatic start_cond(bit stop);
        put_event(KIND_START, 8'($urandom), stop, 8'($urandom), 1'($urandom));
    endtask

    task automatic overflow(bit [7:0] line);
        put_event(KIND_OVERFLOW, line, 1'($urandom), 8'($urandom), 1'($urandom));
    endtask

    // let every due word come out, then idle so the pipeline drains
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // setup then access, followed by a read back of the register
    task automatic write_own_address(logic [7:0] value);
        logic [31:0] word;
        word = {24'($urandom), value};    // upper bits are junk the block must drop
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_OWN_ADDRESS;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        sb.set_own_addr(word);
        own_cfg = value;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        pwdata  <= 32'($urandom);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (prdata[7:0] !== value) begin
            $error("own_address: expected %0h, actual %0h", value, prdata[7:0]);
            sb.fails++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // start, address, a burst of data in the chosen direction, mostly a stop at the end
    task automatic run_transfer(bit force_write, int len);
        int         sel;
        int         n;
        bit [7:0]   adr;
        bit         rw;
        quiet = ($urandom_range(0, 5) == 0);
        start_cond(1'b0);
        sel = $urandom_range(0, 99);
        rw  = force_write ? 1'b0 : 1'($urandom);
        if (sel < 65 || force_write)
            adr = {own_cfg[7:1], rw};
        else if (sel < 80)
            adr = 8'h00;                       // general call
        else
            adr = 8'($urandom);
        overflow(adr);
        n = (len >= 0) ? len : $urandom_range(0, 6);
        if (adr[0]) begin
            overflow(8'($urandom));            // first byte out
            for (int i = 0; i < n; i++) begin
                overflow(8'($urandom));        // ack bit slot
                overflow(8'h00);               // master ack, next byte out
            end
            overflow(8'($urandom));
            overflow(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
        end
        else begin
            for (int i = 0; i < n; i++) begin
                overflow(8'($urandom));        // data byte
                overflow(8'($urandom));        // ack slot, host decides
            end
        end
        if ($urandom_range(0, 9) < 7)
            start_cond(1'b1);
    endtask

    initial
    begin : stimulus
        logic [7:0] settings[5];
        int         target;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        quiet          = 1'b0;
        own_cfg        = 8'd0;
        events_sent    = 0;
        settings_used  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk through each branch of the sequencer
        write_own_address(8'hA4);
        put_event(KIND_OVERFLOW, 8'hFF, 1'b1, 8'hFF, 1'b1);   // overflow while idle
        start_cond(1'b0);
        overflow(8'hA4);                                       // own address, write
        overflow(8'hFF);
        put_event(KIND_OVERFLOW, 8'h5A, 1'b0, 8'h00, 1'b1);   // host acks
        overflow(8'h00);
        put_event(KIND_OVERFLOW, 8'hFF, 1'b0, 8'hFF, 1'b0);   // host nacks
        start_cond(1'b1);
        start_cond(1'b0);
        overflow(8'hA5);                                       // own address, read
        put_event(KIND_OVERFLOW, 8'h00, 1'b0, 8'hFF, 1'b0);
        overflow(8'hFF);
        put_event(KIND_OVERFLOW, 8'h00, 1'b1, 8'h00, 1'b1);   // master ack
        overflow(8'h00);
        overflow(8'h80);                                       // master nack
        start_cond(1'b0);
        overflow(8'h42);                                       // address mismatch
        start_cond(1'b0);
        overflow(8'h00);                                       // general call
        start_cond(1'b0);
        overflow(8'h01);                                       // odd address, no match
        start_cond(1'b1);
        put_event(KIND_OVERFLOW, 8'h00, 1'b0, 8'h00, 1'b0);
        settle();

        // address settings: both ends, one with the r/w bit set, then random ones
        settings = '{8'h00, 8'hFE, 8'h01, 8'($urandom_range(0, 127) * 2),
                     8'($urandom_range(0, 254))};
        target = events_sent;
        foreach (settings[p]) begin
            write_own_address(settings[p]);
            if (p == 1)
                run_transfer(1'b1, 257);       // byte counter wraps past 255
            target = events_sent + 120;
            while (events_sent < target) begin
                if ($urandom_range(0, 99) < 15) begin
                    quiet = 1'b0;
                    repeat ($urandom_range(1, 3))
                        put_event(1'($urandom), 8'($urandom), 1'($urandom),
                                  8'($urandom), 1'($urandom));
                end
                else begin
                    run_transfer(1'b0, -1);
                end
            end
            quiet = 1'b0;
            settle();
        end

        $display("%0d event words sent under %0d address settings, %0d result words checked",
                 events_sent, settings_used, sb.checked);
        if (sb.fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
rtl/i2cs_pkg.sv
rtl/i2cs_step.sv
rtl/i2c_slave_byte_fsm.sv
dv/i2c_slave_byte_fsm_tb.sv
